### hdl/runtime_fairness_monitor_defines.svh
// Assertion macros for the runtime fairness monitor checker.
// Used by hdl/rfm_checker.sv; no other dependencies.
`ifndef RUNTIME_FAIRNESS_MONITOR_DEFINES_SVH
`define RUNTIME_FAIRNESS_MONITOR_DEFINES_SVH

// same-cycle implication
`define RFM_ASSERT_IMP(lbl, ck, rn, a, c, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define RFM_ASSERT_NXT(lbl, ck, rn, a, c, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) else $error(msg);

`endif

### hdl/rfm_pkg.sv
// Shared types and constants for the runtime fairness monitor.
// No dependencies.
`default_nettype none
package rfm_pkg;

	localparam int unsigned SCALE = 1000;

	localparam logic [2:0] MODE_REG   = 3'd0;
	localparam logic [2:0] MODE_START = 3'd1;
	localparam logic [2:0] MODE_STOP  = 3'd2;
	localparam logic [2:0] MODE_QUERY = 3'd3;
	localparam logic [2:0] MODE_CLEAR = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_RUNNING  = 3'd2;
	localparam logic [2:0] ST_IDLE     = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	// table write controls
	typedef struct packed {
		logic we_id;
		logic we_start;
		logic we_rt;
		logic set_run;
		logic clr_run;
		logic clr_all;
	} tbl_ctl_t;

	// multiplier jobs
	typedef enum logic [2:0] {
		OP_SQ = 3'd0,
		OP_SS = 3'd1,
		OP_NL = 3'd2,
		OP_NH = 3'd3,
		OP_DL = 3'd4,
		OP_DH = 3'd5
	} mop_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_CHK  = 8'b0000_0100,
		S_UPD  = 8'b0000_1000,
		S_MWT  = 8'b0001_0000,
		S_FIN  = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

endpackage
`default_nettype wire

### hdl/rfm_table.sv
// Task table: id, start stamp and run time memories plus running flags.
// Depends on rfm_pkg.
`default_nettype none
module rfm_table import rfm_pkg::*; #(
	parameter int MAX_ENTRIES   = 64,
	parameter int RUNTIME_WIDTH = 32,
	parameter int AW            = 6
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire tbl_ctl_t                 ctl,
	input  wire logic [AW-1:0]            addr,
	input  wire logic [30:0]              wr_id,
	input  wire logic [63:0]              wr_start,
	input  wire logic [RUNTIME_WIDTH-1:0] wr_rt,
	output logic      [30:0]              rd_id,
	output logic      [63:0]              rd_start,
	output logic      [RUNTIME_WIDTH-1:0] rd_rt,
	output logic                          rd_run
);

	logic [30:0]              id_mem    [MAX_ENTRIES];
	logic [63:0]              start_mem [MAX_ENTRIES];
	logic [RUNTIME_WIDTH-1:0] rt_mem    [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]   run_q;

	always_ff @(posedge clk) begin
		if (ctl.we_id) id_mem[addr] <= wr_id;
		if (ctl.we_start) start_mem[addr] <= wr_start;
		if (ctl.we_rt) rt_mem[addr] <= wr_rt;
		rd_id    <= id_mem[addr];
		rd_start <= start_mem[addr];
		rd_rt    <= rt_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			rd_run <= 1'b0;
		end else begin
			if (ctl.clr_all) run_q <= '0;
			else if (ctl.set_run) run_q[addr] <= 1'b1;
			else if (ctl.clr_run) run_q[addr] <= 1'b0;
			rd_run <= run_q[addr];
		end
	end

endmodule
`default_nettype wire

### hdl/rfm_mul.sv
// Shared 64x64 multiplier: four 32x32 partial products, one per cycle.
// Depends on rfm_pkg.
`default_nettype none
module rfm_mul import rfm_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic [63:0]  a,
	input  wire logic [63:0]  b,
	output logic              done,
	output logic      [127:0] p
);

	logic [63:0]  a_q, b_q;
	logic [1:0]   k_q, sh_s1;
	logic         run_q, pv_s1;
	logic [63:0]  prd_s1;
	logic [31:0]  ah, bh;
	logic [6:0]   shamt;

	assign ah = k_q[1] ? a_q[63:32] : a_q[31:0];
	assign bh = k_q[0] ? b_q[63:32] : b_q[31:0];
	assign shamt = 7'(({1'b0, sh_s1[1]} + {1'b0, sh_s1[0]})) << 5;

	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= b;
		end
		prd_s1 <= ah * bh;
		sh_s1  <= k_q;
		if (go) p <= '0;
		else if (pv_s1) p <= p + ({64'd0, prd_s1} << shamt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			run_q <= 1'b0;
			pv_s1 <= 1'b0;
			done  <= 1'b0;
		end else begin
			done  <= pv_s1 && (sh_s1 == 2'd3);
			pv_s1 <= run_q;
			if (go) begin
				k_q   <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd3) run_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/runtime_fairness_monitor.sv
// Register/clear: table write in S_RD, then the result. Start/stop: S_RD and S_CHK per entry scanned.
// Query: per entry a table read, a compare and a square on the shared multiplier,
// then 5 multiplier jobs and a 10-step restoring divide.
// One word in flight at a time; in_ready only in idle. Async reset clears count,
// running flags and output valid; table memories are not cleared.
`default_nettype none
module runtime_fairness_monitor import rfm_pkg::*; #(
	parameter int MAX_ENTRIES   = 64,
	parameter int RUNTIME_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  mode,
	input  wire logic [30:0] task_id,
	input  wire logic [63:0] timestamp,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [2:0]  status,
	output logic      [9:0]  fairness
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [RUNTIME_WIDTH-1:0] RT_MAX = '1;

	state_t state_q;
	mop_t   op_q;

	// captured word
	logic [2:0]  mode_q;
	logic [30:0] id_q;
	logic [63:0] ts_q;

	logic [CW-1:0] count_q, idx_q, idx_nx;

	// table
	tbl_ctl_t                 ctl;
	logic [30:0]              wr_id, rd_id;
	logic [63:0]              wr_start, rd_start;
	logic [RUNTIME_WIDTH-1:0] wr_rt, rd_rt;
	logic                     rd_run;

	// arithmetic
	logic         mgo_q, mdone;
	logic [63:0]  ma_q, mb_q, sum_q, el_q;
	logic [127:0] mp, sq_q, tmp_q, num_q, den_q, dsh;
	logic [64:0]  tot;
	logic [3:0]   dbit_q;
	logic [9:0]   quo_q;

	logic [2:0]   rs_q;
	logic [9:0]   rf_q;

	assign in_ready = (state_q == S_IDLE);
	assign idx_nx   = idx_q + CW'(1);
	assign tot      = {1'b0, el_q} + 65'(rd_rt);
	assign dsh      = den_q << dbit_q;

	// table write controls follow from state and mode
	always_comb begin
		ctl      = '0;
		wr_id    = id_q;
		wr_start = '0;
		wr_rt    = '0;
		case (state_q)
			S_RD: begin
				if (mode_q == MODE_REG) begin
					ctl.we_id    = 1'b1;
					ctl.we_start = 1'b1;
					ctl.we_rt    = 1'b1;
					ctl.clr_run  = 1'b1;
				end else if (mode_q == MODE_CLEAR) begin
					ctl.clr_all = 1'b1;
				end
			end
			S_CHK: begin
				if (mode_q == MODE_START && rd_id == id_q && !rd_run) begin
					ctl.we_start = 1'b1;
					ctl.set_run  = 1'b1;
					wr_start     = ts_q;
				end
			end
			S_UPD: begin
				ctl.we_start = 1'b1;
				ctl.we_rt    = 1'b1;
				ctl.clr_run  = 1'b1;
				wr_rt = (tot >= 65'(RT_MAX)) ? RT_MAX : tot[RUNTIME_WIDTH-1:0];
			end
			default: ;
		endcase
	end

	rfm_table #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.RUNTIME_WIDTH(RUNTIME_WIDTH),
		.AW           (AW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.addr    (idx_q[AW-1:0]),
		.wr_id   (wr_id),
		.wr_start(wr_start),
		.wr_rt   (wr_rt),
		.rd_id   (rd_id),
		.rd_start(rd_start),
		.rd_rt   (rd_rt),
		.rd_run  (rd_run)
	);

	rfm_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mgo_q),
		.a     (ma_q),
		.b     (mb_q),
		.done  (mdone),
		.p     (mp)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q <= mode;
				id_q   <= task_id;
				ts_q   <= timestamp;
				sum_q  <= '0;
				sq_q   <= '0;
			end
			S_CHK: begin
				el_q <= ts_q - rd_start;
				if (mode_q == MODE_QUERY) begin
					sum_q <= sum_q + 64'(rd_rt);
					ma_q  <= 64'(rd_rt);
					mb_q  <= 64'(rd_rt);
				end
			end
			S_MWT: begin
				if (mdone) begin
					case (op_q)
						OP_SQ: sq_q <= sq_q + mp;
						OP_SS: begin
							tmp_q <= mp;
							ma_q  <= mp[63:0];
							mb_q  <= 64'(SCALE);
						end
						OP_NL: begin
							num_q <= mp;
							ma_q  <= tmp_q[127:64];
							mb_q  <= 64'(SCALE);
						end
						OP_NH: begin
							num_q <= num_q + (mp << 64);
							ma_q  <= sq_q[63:0];
							mb_q  <= 64'(count_q);
						end
						OP_DL: begin
							den_q <= mp;
							ma_q  <= sq_q[127:64];
							mb_q  <= 64'(count_q);
						end
						OP_DH: begin
							den_q  <= den_q + (mp << 64);
							dbit_q <= 4'd9;
							quo_q  <= '0;
						end
						default: ;
					endcase
				end
			end
			S_FIN: begin
				ma_q <= sum_q;
				mb_q <= sum_q;
			end
			S_DIV: begin
				// restoring step: quotient is at most 1000, so ten bits
				if (dsh <= num_q) begin
					num_q <= num_q - dsh;
					quo_q[dbit_q] <= 1'b1;
				end
				dbit_q <= dbit_q - 4'd1;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_SQ;
			count_q   <= '0;
			idx_q     <= '0;
			mgo_q     <= 1'b0;
			rs_q      <= ST_OK;
			rf_q      <= '0;
			out_valid <= 1'b0;
			status    <= ST_OK;
			fairness  <= '0;
		end else begin
			mgo_q <= 1'b0;
			// S_OUT handles its own valid update
			if (out_valid && out_ready && state_q != S_OUT) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						rs_q    <= ST_OK;
						rf_q    <= '0;
						idx_q   <= '0;
						state_q <= S_OUT;
						case (mode)
							MODE_REG: begin
								if (count_q == CW'(MAX_ENTRIES)) rs_q <= ST_FULL;
								else begin
									idx_q   <= count_q;
									state_q <= S_RD;
								end
							end
							MODE_START, MODE_STOP: begin
								if (count_q == '0) rs_q <= ST_NOTFOUND;
								else state_q <= S_RD;
							end
							MODE_QUERY: begin
								if (count_q != '0) state_q <= S_RD;
							end
							MODE_CLEAR: state_q <= S_RD;
							default: ;
						endcase
					end
				end
				S_RD: begin
					// register/clear write here; others wait for read data
					if (mode_q == MODE_REG) begin
						count_q <= count_q + CW'(1);
						state_q <= S_OUT;
					end else if (mode_q == MODE_CLEAR) begin
						count_q <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (mode_q == MODE_QUERY) begin
						mgo_q   <= 1'b1;
						op_q    <= OP_SQ;
						state_q <= S_MWT;
					end else if (rd_id == id_q) begin
						if (mode_q == MODE_START) begin
							rs_q    <= rd_run ? ST_RUNNING : ST_OK;
							state_q <= S_OUT;
						end else if (!rd_run) begin
							rs_q    <= ST_IDLE;
							state_q <= S_OUT;
						end else begin
							state_q <= S_UPD;
						end
					end else if (idx_nx == count_q) begin
						rs_q    <= ST_NOTFOUND;
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_nx;
						state_q <= S_RD;
					end
				end
				S_UPD: state_q <= S_OUT;
				S_MWT: begin
					if (mdone) begin
						case (op_q)
							OP_SQ: begin
								if (idx_nx == count_q) state_q <= S_FIN;
								else begin
									idx_q   <= idx_nx;
									state_q <= S_RD;
								end
							end
							OP_SS: begin op_q <= OP_NL; mgo_q <= 1'b1; end
							OP_NL: begin op_q <= OP_NH; mgo_q <= 1'b1; end
							OP_NH: begin op_q <= OP_DL; mgo_q <= 1'b1; end
							OP_DL: begin op_q <= OP_DH; mgo_q <= 1'b1; end
							OP_DH: state_q <= S_DIV;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_FIN: begin
					// all-zero run times give index 0
					if (sq_q == '0) state_q <= S_OUT;
					else begin
						op_q    <= OP_SS;
						mgo_q   <= 1'b1;
						state_q <= S_MWT;
					end
				end
				S_DIV: begin
					if (dbit_q == 4'd0) begin
						rf_q    <= quo_q | ((dsh <= num_q) ? 10'd1 : 10'd0);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						status    <= rs_q;
						fairness  <= rf_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/rfm_checker.sv
// Port-level checks for the runtime fairness monitor, bound to the top level.
// Depends on runtime_fairness_monitor_defines.svh.
`default_nettype none
`include "runtime_fairness_monitor_defines.svh"
module rfm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [9:0]  fairness
);

	`RFM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(fairness), "result word changed while stalled")
	`RFM_ASSERT_NXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready, "accepted a word while busy")
	`RFM_ASSERT_IMP(a_fair_rng, clk, arst_n, out_valid, fairness <= 10'd1000, "fairness above 1000")
	`RFM_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && status != 3'd0, fairness == 10'd0, "fairness set with error status")

endmodule

bind runtime_fairness_monitor rfm_checker u_rfm_checker (.*);
`default_nettype wire
